### sv/nsdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsdp_pkg
// Shared types, widths and the sigmoid lookup table of the neuron block.
// ----------------------------------------------------------------------------
package nsdp_pkg;

  localparam int WEIGHT_W   = 16;
  localparam int ACT_W      = 16;
  localparam int INV_W      = 17;
  localparam int OUT_W      = 16;
  localparam int ACC_W      = 40;
  localparam int TERM_W     = 33;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 18;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int RANGE_W    = 32;
  localparam int MAX_INPUTS = 256;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
  localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ACC,
    S_IDX,
    S_LOOK
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WI,
    OP_ACT,
    OP_IDX
  } mul_op_t;

  typedef struct packed {
    logic    in_ready;
    mul_op_t op;
    logic    mul_en;
    logic    acc_step;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_free;
  } status_t;

  typedef logic [OUT_W-1:0] sig_table_t [SIG_DEPTH];

  localparam longint ONE_Q31  = 64'sd2147483648;
  localparam longint HALF_Q31 = 64'sd1073741824;

  // Restoring division of non-negative values, used at elaboration only.
  function automatic longint udiv(input longint n, input longint d);
    logic [63:0] nu;
    logic [63:0] du;
    logic [63:0] q;
    logic [64:0] r;
    nu = 64'(n);
    du = 64'(d);
    q  = '0;
    r  = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], nu[i]};
      if (r >= {1'b0, du}) begin
        r    = r - {1'b0, du};
        q[i] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  // e^-t with t in Q.28, result in Q.31
  function automatic longint exp_neg_q31(input longint t);
    longint y;
    longint term;
    longint sum;
    y    = t >>> 1;
    term = ONE_Q31;
    sum  = ONE_Q31;
    for (int k = 1; k <= 14; k++) begin
      term = udiv((term * y) >>> 31, longint'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum + HALF_Q31) >>> 31;
    end
    return sum;
  endfunction

  function automatic logic [OUT_W-1:0] sigmoid_q16(input longint x);
    longint mag;
    longint e;
    longint num;
    longint den;
    longint r;
    mag = (x < 0) ? -x : x;
    e   = exp_neg_q31(mag);
    num = (x >= 0) ? ONE_Q31 : e;
    den = ONE_Q31 + e;
    r   = udiv((num <<< 16) + (den >>> 1), den);
    if (r > 65535) begin
      r = 65535;
    end
    return OUT_W'(r);
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t tbl;
    longint     mid;
    for (int i = 0; i < SIG_DEPTH; i++) begin
      mid    = (((2 * longint'(i) + 1) <<< 31) / SIG_DEPTH) - ONE_Q31;
      tbl[i] = sigmoid_q16(mid);
    end
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

### sv/nsdp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsdp interfaces
// Valid/ready channels for input items, result items and the register write.
// ----------------------------------------------------------------------------
interface nsdp_in_if;
  import nsdp_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight;
  logic        [ACT_W-1:0]    activation;
  logic                       last;
  modport source (output valid, output weight, output activation, output last,
                  input ready);
  modport sink (input valid, input weight, input activation, input last,
                output ready);
endinterface

interface nsdp_out_if;
  import nsdp_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] neuron_out;
  logic             clamped;
  modport source (output valid, output neuron_out, output clamped, input ready);
  modport sink (input valid, input neuron_out, input clamped, output ready);
endinterface

interface nsdp_cfg_if;
  import nsdp_pkg::*;
  logic             valid;
  logic             ready;
  logic [INV_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/nsdp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsdp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module nsdp_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [nsdp_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [nsdp_pkg::MUL_B_W-1:0] b,
  output logic signed      [nsdp_pkg::MUL_P_W-1:0] p
);
  import nsdp_pkg::*;

  logic signed [MUL_P_W-1:0] prod;

  assign prod = MUL_P_W'(a) * MUL_P_W'(b);

  // hold the product until the next step loads the unit
  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod;
    end
  end

endmodule
`default_nettype wire

### sv/nsdp_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsdp_seq
// Sequencer that steps the shared multiplier through one item.
// ----------------------------------------------------------------------------
module nsdp_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nsdp_pkg::status_t status,
  output nsdp_pkg::ctrl_t        ctrl,
  output nsdp_pkg::state_t       state
);
  import nsdp_pkg::*;

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.in_ready = 1'b0;
    ctrl.op       = OP_NONE;
    ctrl.mul_en   = 1'b0;
    ctrl.acc_step = 1'b0;
    ctrl.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        ctrl.op     = OP_WI;
        ctrl.mul_en = 1'b1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        ctrl.op     = OP_ACT;
        ctrl.mul_en = 1'b1;
        state_next  = S_ACC;
      end
      S_ACC: begin
        ctrl.acc_step = 1'b1;
        if (status.last) begin
          state_next = S_IDX;
        end else begin
          // take the next item straight away
          ctrl.in_ready = 1'b1;
          state_next    = status.in_valid ? S_MUL1 : S_IDLE;
        end
      end
      S_IDX: begin
        ctrl.op     = OP_IDX;
        ctrl.mul_en = 1'b1;
        state_next  = S_LOOK;
      end
      S_LOOK: begin
        if (status.out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/neuron_sigmoid_dot_product_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neuron_sigmoid_dot_product_top
// One sigmoid neuron evaluated over a run of weight/activation items.
// ----------------------------------------------------------------------------
// Usage:
//   src carries items of weight (Q4.12), activation (Q0.16) and last. Each
//   item adds floor(weight * inv_count * activation / 2^16) to a saturating
//   40-bit Q12.28 accumulator. The item marked last closes the neuron: the
//   sum is clamped to [-8,8), indexed into the sigmoid table and one result
//   item (neuron_out, clamped) is sent on res; the accumulator is cleared.
//   cfg writes inv_count (Q1.16) and is always ready; write it only while
//   the block is idle.
// Sequence:
//   One shared 34x18 multiplier is used twice per item (weight by
//   inv_count, then by activation) plus once more for the table index on a
//   last item. An item without last passes through the MUL1, MUL2 and ACC
//   steps; a following item is taken in ACC. A last item goes on through
//   IDX to LOOK, loads the result once res is free, then takes items again.
// Reset clears the accumulator, sets inv_count to 1.0 and empties res.
// A stalled receiver holds the result register. Items keep flowing while it
//   waits; a further last item then holds in the lookup step and no item is
//   taken until the register drains.
// ----------------------------------------------------------------------------
module neuron_sigmoid_dot_product_top (
  input wire logic  clk,
  input wire logic  rst,
  nsdp_in_if.sink   src,
  nsdp_out_if.source res,
  nsdp_cfg_if.sink  cfg
);
  import nsdp_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  state_t  state;

  logic        [INV_W-1:0]    inv_count;
  logic signed [WEIGHT_W-1:0] w_r;
  logic        [ACT_W-1:0]    act_r;
  logic                       last_r;
  logic signed [ACC_W-1:0]    acc;
  logic        [RANGE_W-1:0]  u_r;
  logic                       clamp_r;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;

  logic signed [TERM_W-1:0]   term;
  logic signed [ACC_W:0]      sum_wide;
  logic signed [ACC_W-1:0]    sum_sat;
  logic                       in_range;
  logic        [RANGE_W-1:0]  u_next;
  logic        [SIG_IDX_W-1:0] sig_idx;

  logic in_fire;

  // register write port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_count <= INV_RESET;
    end else if (cfg.valid) begin
      inv_count <= cfg.data;
    end
  end

  // sequencer
  assign src.ready       = ctrl.in_ready;
  assign in_fire         = src.valid && ctrl.in_ready;
  assign status.in_valid = src.valid;
  assign status.last     = last_r;
  assign status.out_free = !res.valid || res.ready;

  nsdp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .state  (state)
  );

  // capture the item; it is held for the whole multiply sequence
  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r    <= src.weight;
      act_r  <= src.activation;
      last_r <= src.last;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.op)
      OP_WI: begin
        mul_a = MUL_A_W'(w_r);
        mul_b = {1'b0, inv_count};
      end
      OP_ACT: begin
        // weight * inv_count fits in 33 signed bits
        mul_a = prod[MUL_A_W-1:0];
        mul_b = {{(MUL_B_W - ACT_W){1'b0}}, act_r};
      end
      OP_IDX: begin
        mul_a = {{(MUL_A_W - RANGE_W){1'b0}}, u_r};
        mul_b = MUL_B_W'(SIG_DEPTH);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  nsdp_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // floor of the product over 2^16: drop the low bits of the two's complement
  assign term     = prod[16 +: TERM_W];
  assign sum_wide = (ACC_W + 1)'(acc) + (ACC_W + 1)'(term);

  // saturate to 40 bits
  always_comb begin
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
  end

  // clamp to [-8,8) and offset to an unsigned position in the table range
  assign in_range = (&sum_sat[ACC_W-1:RANGE_W-1]) || !(|sum_sat[ACC_W-1:RANGE_W-1]);
  always_comb begin
    if (in_range) begin
      u_next = {~sum_sat[RANGE_W-1], sum_sat[RANGE_W-2:0]};
    end else if (sum_sat[ACC_W-1]) begin
      u_next = '0;
    end else begin
      u_next = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.acc_step) begin
      // clear on the last item; the result goes on from u_r
      acc <= last_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_step) begin
      u_r     <= u_next;
      clamp_r <= !in_range;
    end
  end

  // (position * depth) >> 32 always lies below the depth
  assign sig_idx = prod[RANGE_W +: SIG_IDX_W];

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctrl.out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      res.neuron_out <= SIG_TABLE[sig_idx];
      res.clamped    <= clamp_r;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!res.valid || res.ready))
    else $error("result register overwritten while still pending");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (acc == '0))
    else $error("accumulator not cleared at end of neuron");

  a_clamp_edge: assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_load && clamp_r) |-> (u_r == '0 || u_r == '1))
    else $error("clamped sum not at edge of table range");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.mul_en |-> !src.ready)
    else $error("item taken while multiplier busy");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    (ctrl.acc_step && last_r) |=> ##1 (state == S_LOOK))
    else $error("last item did not reach lookup");

endmodule
`default_nettype wire
